### rtl/core/spvr_pkg.sv
package spvr_pkg;

	// Fixed field widths of the access channel.
	localparam int IDX_W  = 18;
	localparam int DATA_W = 16;
	localparam int BYTE_W = 8;

	// Default store depth in pixel words.
	localparam int STORE_WORDS_DEF = 262144;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Access codes.
	typedef enum logic [1:0] {
		REQ_COLOR_WR = 2'd0,
		REQ_COLOR_RD = 2'd1,
		REQ_PAL_WR   = 2'd2,
		REQ_PAL_RD   = 2'd3
	} req_t;

	// Classified access as it travels from the front to the back.
	typedef struct packed {
		req_t              req;
		logic              wr;
		logic [DATA_W-1:0] data;
		logic [DATA_W-1:0] keep;
	} op_t;

endpackage

### rtl/core/split_plane_video_ram_port.sv
// Channel  Handshake                Word
// -------  -----------------------  ------------------------------------------
// in       in_valid / in_ready      req_type, pair_index, write_data, keep_mask
// out      out_valid / out_ready    read_data
// cfg      cfg_valid / cfg_ready    palette_fill
//
// Each word takes two reads of the store's single read port (one per pixel word);
// the next word is taken into the read stage with the second read of the last one.
// A word passes through the queue, the read stage, the merge stage and the output register.
// Reset clears all control state and the palette fill; the pixel store is not cleared.
// A result held on the output stalls the merge stage, then the reads, then the queue.
module split_plane_video_ram_port #(
	parameter int STORE_WORDS = spvr_pkg::STORE_WORDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [spvr_pkg::IDX_W-1:0]  pair_index,
	input  logic [spvr_pkg::DATA_W-1:0] write_data,
	input  logic [spvr_pkg::DATA_W-1:0] keep_mask,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [spvr_pkg::DATA_W-1:0] read_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [spvr_pkg::DATA_W-1:0] palette_fill
);
	import spvr_pkg::*;

	localparam int AW = $clog2(STORE_WORDS);
	localparam int QW = $bits(op_t) + 2 * AW;

	logic          push;
	op_t           f_op;
	logic [AW-1:0] f_a0;
	logic [AW-1:0] f_a1;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	logic [QW-1:0] q_data;
	op_t           q_op;
	logic [AW-1:0] q_a0;
	logic [AW-1:0] q_a1;

	// Front: classify and reduce the address.
	spvr_front #(
		.STORE_WORDS (STORE_WORDS)
	) u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.pair_index (pair_index),
		.write_data (write_data),
		.keep_mask  (keep_mask),
		.q_full     (q_full),
		.push       (push),
		.op         (f_op),
		.a0         (f_a0),
		.a1         (f_a1)
	);

	// Queue between front and back.
	spvr_fifo #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({f_op, f_a0, f_a1}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	assign {q_op, q_a0, q_a1} = q_data;

	// Back: read, merge and write the pixel pair.
	spvr_back #(
		.STORE_WORDS (STORE_WORDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_vld        (!q_empty),
		.q_pop        (q_pop),
		.q_op         (q_op),
		.q_a0         (q_a0),
		.q_a1         (q_a1),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.palette_fill (palette_fill),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_data    (read_data)
	);

endmodule

### rtl/core/spvr_front.sv
module spvr_front #(
	parameter int STORE_WORDS = spvr_pkg::STORE_WORDS_DEF
) (
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         req_type,
	input  logic [spvr_pkg::IDX_W-1:0]         pair_index,
	input  logic [spvr_pkg::DATA_W-1:0]        write_data,
	input  logic [spvr_pkg::DATA_W-1:0]        keep_mask,
	input  logic                               q_full,
	output logic                               push,
	output spvr_pkg::op_t                      op,
	output logic [$clog2(STORE_WORDS)-1:0]     a0,
	output logic [$clog2(STORE_WORDS)-1:0]     a1
);
	import spvr_pkg::*;

	localparam int AW    = $clog2(STORE_WORDS);
	// Compare width: holds the store depth shifted up to just past the index range.
	localparam int CW    = ((AW > IDX_W) ? AW : IDX_W) + 2;
	localparam int QMAX  = ((1 << IDX_W) - 1) / STORE_WORDS;
	localparam int NSTEP = $clog2(QMAX + 1);

	logic [CW-1:0] rem;
	logic [CW-1:0] rem_inc;
	req_t          req;

	// The front takes a word whenever the queue has room.
	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	// Reduce the index modulo the store depth, one quotient bit per step.
	always_comb begin
		rem = CW'(pair_index);
		for (int k = NSTEP - 1; k >= 0; k--) begin
			if (rem >= (CW'(STORE_WORDS) << k)) begin
				rem = rem - (CW'(STORE_WORDS) << k);
			end
		end
	end

	// The second word of the pair wraps at the end of the store.
	assign rem_inc = rem + CW'(1);
	assign a0      = rem[AW-1:0];
	assign a1      = (rem_inc == CW'(STORE_WORDS)) ? '0 : rem_inc[AW-1:0];

	// Classify the access.
	always_comb begin
		req     = req_t'(req_type);
		op.req  = req;
		op.wr   = (req inside {REQ_COLOR_WR, REQ_PAL_WR});
		op.data = write_data;
		op.keep = keep_mask;
	end

endmodule

### rtl/core/spvr_fifo.sv
module spvr_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = spvr_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	import spvr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == NW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = store_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

### rtl/core/spvr_back.sv
module spvr_back #(
	parameter int STORE_WORDS = spvr_pkg::STORE_WORDS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_vld,
	output logic                               q_pop,
	input  spvr_pkg::op_t                      q_op,
	input  logic [$clog2(STORE_WORDS)-1:0]     q_a0,
	input  logic [$clog2(STORE_WORDS)-1:0]     q_a1,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [spvr_pkg::DATA_W-1:0]        palette_fill,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [spvr_pkg::DATA_W-1:0]        read_data
);
	import spvr_pkg::*;

	localparam int AW = $clog2(STORE_WORDS);

	// Pixel store.
	logic [DATA_W-1:0] mem [STORE_WORDS];
	logic [DATA_W-1:0] mem_rd_q;
	logic [AW-1:0]     rd_addr_q;
	logic              byp_q;
	logic [DATA_W-1:0] byp_data_q;
	logic [DATA_W-1:0] rd_eff;

	// Read stage: fetches the two words of the pair.
	logic              a_vld_q;
	logic              a_ph_q;
	op_t               a_op_q;
	logic [AW-1:0]     a_a0_q;
	logic [AW-1:0]     a_a1_q;

	// Merge stage: holds the first word; the second sits on the read port.
	logic              b_vld_q;
	op_t               b_op_q;
	logic [AW-1:0]     b_a0_q;
	logic [AW-1:0]     b_a1_q;
	logic [DATA_W-1:0] w0_b_q;

	// Write-back of the second word.
	logic              wb_vld_q;
	logic [AW-1:0]     wb_addr_q;
	logic [DATA_W-1:0] wb_data_q;

	logic              out_vld_q;
	logic [DATA_W-1:0] out_data_q;
	logic [DATA_W-1:0] fill_q;

	logic              out_free;
	logic              b_go;
	logic              b_free;
	logic              a_rd0;
	logic              a_rd1;
	logic              a_load;
	logic              re;
	logic [AW-1:0]     raddr;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] lo_pair;
	logic [DATA_W-1:0] hi_pair;
	logic [DATA_W-1:0] lo_new;
	logic [DATA_W-1:0] hi_new;
	logic [DATA_W-1:0] nw0;
	logic [DATA_W-1:0] nw1;
	logic [DATA_W-1:0] res;

	// Stage handshakes.
	assign out_free = !out_vld_q || out_ready;
	assign b_go     = b_vld_q && out_free;
	assign b_free   = !b_vld_q || b_go;
	assign a_rd0    = a_vld_q && !a_ph_q && b_free;
	assign a_rd1    = a_vld_q && a_ph_q;
	assign a_load   = !a_vld_q || a_rd1;
	assign q_pop    = a_load && q_vld;

	// Read port address.
	assign re    = a_rd0 || a_rd1;
	assign raddr = a_ph_q ? a_a1_q : a_a0_q;

	// The read data is corrected by any write that landed after its read.
	assign rd_eff = byp_q ? byp_data_q : mem_rd_q;

	// Merge the pair under the keep mask.
	always_comb begin
		lo_pair = {rd_eff[BYTE_W-1:0], w0_b_q[BYTE_W-1:0]};
		hi_pair = {rd_eff[DATA_W-1:BYTE_W], w0_b_q[DATA_W-1:BYTE_W]};
		lo_new  = lo_pair;
		hi_new  = hi_pair;
		res     = '0;
		case (b_op_q.req)
			REQ_COLOR_WR: begin
				lo_new = (lo_pair & b_op_q.keep) | (b_op_q.data & ~b_op_q.keep);
				hi_new = (hi_pair & b_op_q.keep) | (fill_q & ~b_op_q.keep);
			end
			REQ_COLOR_RD: begin
				res = lo_pair;
			end
			REQ_PAL_WR: begin
				hi_new = (hi_pair & b_op_q.keep) | (b_op_q.data & ~b_op_q.keep);
			end
			REQ_PAL_RD: begin
				res = hi_pair;
			end
			default: begin
				res = '0;
			end
		endcase
		nw0 = {hi_new[BYTE_W-1:0], lo_new[BYTE_W-1:0]};
		nw1 = {hi_new[DATA_W-1:BYTE_W], lo_new[DATA_W-1:BYTE_W]};
	end

	// Write port: first word at merge, second word in the following cycle.
	assign we    = (b_go && b_op_q.wr) || wb_vld_q;
	assign waddr = wb_vld_q ? wb_addr_q : b_a0_q;
	assign wdata = wb_vld_q ? wb_data_q : nw0;

	// Memory array with one write and one registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			mem_rd_q <= mem[raddr];
		end
	end

	// Read-side payload.
	always_ff @(posedge clk) begin
		if (re) begin
			rd_addr_q  <= raddr;
			byp_data_q <= wdata;
		end else if (we && (waddr == rd_addr_q)) begin
			byp_data_q <= wdata;
		end
	end

	// Bypass flag covers a write to the word the read port holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (re) begin
			byp_q <= we && (waddr == raddr);
		end else if (we && (waddr == rd_addr_q)) begin
			byp_q <= 1'b1;
		end
	end

	// Read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_q <= 1'b0;
			a_ph_q  <= 1'b0;
		end else if (a_load) begin
			a_vld_q <= q_vld;
			a_ph_q  <= 1'b0;
		end else if (a_rd0) begin
			a_ph_q  <= 1'b1;
		end
	end

	// Read stage payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			a_op_q <= q_op;
			a_a0_q <= q_a0;
			a_a1_q <= q_a1;
		end
	end

	// Merge stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_vld_q <= 1'b0;
		end else if (a_rd1) begin
			b_vld_q <= 1'b1;
		end else if (b_go) begin
			b_vld_q <= 1'b0;
		end
	end

	// Merge stage payload; the held first word follows later writes to it.
	always_ff @(posedge clk) begin
		if (a_rd1) begin
			b_op_q <= a_op_q;
			b_a0_q <= a_a0_q;
			b_a1_q <= a_a1_q;
			w0_b_q <= (we && (waddr == rd_addr_q)) ? wdata : rd_eff;
		end else if (we && (waddr == b_a0_q)) begin
			w0_b_q <= wdata;
		end
	end

	// Second-word write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_vld_q <= 1'b0;
		end else begin
			wb_vld_q <= b_go && b_op_q.wr;
		end
	end

	always_ff @(posedge clk) begin
		if (b_go) begin
			wb_addr_q <= b_a1_q;
			wb_data_q <= nw1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (b_go) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (b_go) begin
			out_data_q <= res;
		end
	end

	// Palette fill register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cfg_valid) begin
			fill_q <= palette_fill;
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_vld_q;
	assign read_data = out_data_q;

endmodule
